// ----- hw/rtl/agrs_pkg.sv -----
// ----------------------------------------------------------------------------
// agrs_pkg
// Shared types and constants of the alignment gap-run segmenter.
// ----------------------------------------------------------------------------
package agrs_pkg;

  localparam int unsigned DEFAULT_COLUMN_BITS = 20;
  localparam int unsigned REGION_W            = 20;
  localparam int unsigned COORD_W             = 32;
  localparam int unsigned POS_W               = 33;
  localparam int unsigned CHAR_W              = 8;
  localparam int unsigned CFG_W               = 32;
  localparam int unsigned CFG_ADDR_W          = 3;

  localparam logic [CHAR_W-1:0] GAP_CHAR = 8'd45;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_REF_START        = 3'd0,
    CFG_REF_SRC_LEN      = 3'd1,
    CFG_REF_REVERSE      = 3'd2,
    CFG_OTHER_START      = 3'd3,
    CFG_OTHER_SRC_LEN    = 3'd4,
    CFG_OTHER_REVERSE    = 3'd5,
    CFG_REGION_FIRST     = 3'd6,
    CFG_REGION_LAST      = 3'd7
  } cfg_idx_t;

endpackage

// ----- hw/rtl/agrs_tracker.sv -----
// ----------------------------------------------------------------------------
// agrs_tracker
// Column counters, gap counters, run state; flags columns closing a segment.
// ----------------------------------------------------------------------------
module agrs_tracker #(
  parameter int unsigned COLUMN_BITS = agrs_pkg::DEFAULT_COLUMN_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  logic [agrs_pkg::CHAR_W-1:0]       ref_char,
  input  logic [agrs_pkg::CHAR_W-1:0]       other_char,
  input  logic                              block_begin,
  input  logic [agrs_pkg::REGION_W-1:0]     region_first,
  input  logic [agrs_pkg::REGION_W-1:0]     region_last,
  output logic                              emit,
  output logic [COLUMN_BITS:0]              seg_len,
  output logic [COLUMN_BITS:0]              ref_local,
  output logic [COLUMN_BITS:0]              other_local
);
  import agrs_pkg::*;

  localparam int unsigned L_W   = COLUMN_BITS + 1;
  localparam int unsigned CMP_W = (COLUMN_BITS > REGION_W) ? COLUMN_BITS : REGION_W;

  logic [COLUMN_BITS-1:0] column_index_r, column_index_nxt;
  logic [L_W-1:0]         ref_gap_r, ref_gap_nxt;
  logic [L_W-1:0]         other_gap_r, other_gap_nxt;
  logic                   in_run_r, in_run_nxt;
  logic [L_W-1:0]         run_count_r, run_count_nxt;
  logic [L_W-1:0]         ref_start_r, ref_start_nxt;
  logic [L_W-1:0]         other_start_r, other_start_nxt;

  logic                   ref_gap, other_gap, in_region, is_last, run_open;
  logic [COLUMN_BITS-1:0] col;
  logic [CMP_W-1:0]       col_cmp, first_cmp, last_cmp;
  logic [L_W-1:0]         run_base, run_inc, ref_new, other_new;

  always_comb begin
    ref_gap   = (ref_char == GAP_CHAR);
    other_gap = (other_char == GAP_CHAR);
    col       = block_begin ? '0 : column_index_r;
    run_open  = block_begin ? 1'b0 : in_run_r;
    run_base  = block_begin ? '0 : run_count_r;

    ref_gap_nxt   = (block_begin ? '0 : ref_gap_r) + L_W'(ref_gap);
    other_gap_nxt = (block_begin ? '0 : other_gap_r) + L_W'(other_gap);

    col_cmp   = CMP_W'(col);
    first_cmp = CMP_W'(region_first);
    last_cmp  = CMP_W'(region_last);
    in_region = (first_cmp <= col_cmp) && (col_cmp <= last_cmp);
    is_last   = (col_cmp == last_cmp);

    ref_new   = L_W'(col) - ref_gap_nxt;
    other_new = L_W'(col) - other_gap_nxt;
    run_inc   = (run_open ? run_base : '0) + L_W'(1);

    column_index_nxt = col + COLUMN_BITS'(1);
    in_run_nxt       = run_open;
    run_count_nxt    = run_base;
    ref_start_nxt    = ref_start_r;
    other_start_nxt  = other_start_r;
    emit             = 1'b0;
    seg_len          = run_base;
    ref_local        = ref_start_r;
    other_local      = other_start_r;

    if (in_region) begin
      if (other_gap) begin
        emit          = run_open;
        in_run_nxt    = 1'b0;
        run_count_nxt = '0;
      end else begin
        if (!run_open) begin
          ref_start_nxt   = ref_new;
          other_start_nxt = other_new;
        end
        ref_local     = ref_start_nxt;
        other_local   = other_start_nxt;
        seg_len       = run_inc;
        emit          = is_last;
        in_run_nxt    = !is_last;
        run_count_nxt = is_last ? '0 : run_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_index_r <= '0;
      ref_gap_r      <= '0;
      other_gap_r    <= '0;
      in_run_r       <= 1'b0;
      run_count_r    <= '0;
      ref_start_r    <= '0;
      other_start_r  <= '0;
    end else if (step) begin
      column_index_r <= column_index_nxt;
      ref_gap_r      <= ref_gap_nxt;
      other_gap_r    <= other_gap_nxt;
      in_run_r       <= in_run_nxt;
      run_count_r    <= run_count_nxt;
      ref_start_r    <= ref_start_nxt;
      other_start_r  <= other_start_nxt;
    end
  end

endmodule

// ----- hw/rtl/alignment_gap_run_segmenter.sv -----
// ----------------------------------------------------------------------------
// alignment_gap_run_segmenter
// Output: a closed segment moves to the segment, then the output register.
// Throughput: one column per cycle while the result channel does not stall.
// Pipeline: input register, tracker/segment register, position/output register.
// Reset: synchronous; clears counters, run state, config and valid registers.
// ----------------------------------------------------------------------------
module alignment_gap_run_segmenter #(
  parameter int unsigned COLUMN_BITS = agrs_pkg::DEFAULT_COLUMN_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [agrs_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [agrs_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [agrs_pkg::CHAR_W-1:0]          in_ref_char,
  input  logic [agrs_pkg::CHAR_W-1:0]          in_other_char,
  input  logic                                 in_block_begin,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [agrs_pkg::POS_W-1:0]    out_ref_position,
  output logic signed [agrs_pkg::POS_W-1:0]    out_other_position,
  output logic [COLUMN_BITS:0]                 out_run_length,
  output logic                                 out_same_orientation
);
  import agrs_pkg::*;

  localparam int unsigned L_W = COLUMN_BITS + 1;

  logic [COORD_W-1:0]  ref_start_r, ref_len_r, other_start_r, other_len_r;
  logic                ref_rev_r, other_rev_r;
  logic [REGION_W-1:0] region_first_r, region_last_r;
  logic [POS_W-1:0]    ref_base_r, other_base_r;

  logic                in_valid_r;
  logic [CHAR_W-1:0]   ref_char_r, other_char_r;
  logic                begin_r;

  logic                seg_valid_r;
  logic [L_W-1:0]      seg_len_r, seg_ref_r, seg_other_r;

  logic                out_valid_r;
  logic [POS_W-1:0]    out_ref_pos_r, out_other_pos_r;
  logic [L_W-1:0]      out_len_r;
  logic                out_same_r;

  logic                out_load, seg_load, step, emit;
  logic [L_W-1:0]      trk_len, trk_ref, trk_other;
  logic [POS_W-1:0]    ref_c, other_c, len_ext, ref_pos_nxt, other_pos_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_start_r    <= '0;
      ref_len_r      <= '0;
      ref_rev_r      <= 1'b0;
      other_start_r  <= '0;
      other_len_r    <= '0;
      other_rev_r    <= 1'b0;
      region_first_r <= '0;
      region_last_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_REF_START:     ref_start_r    <= cfg_wdata[COORD_W-1:0];
        CFG_REF_SRC_LEN:   ref_len_r      <= cfg_wdata[COORD_W-1:0];
        CFG_REF_REVERSE:   ref_rev_r      <= cfg_wdata[0];
        CFG_OTHER_START:   other_start_r  <= cfg_wdata[COORD_W-1:0];
        CFG_OTHER_SRC_LEN: other_len_r    <= cfg_wdata[COORD_W-1:0];
        CFG_OTHER_REVERSE: other_rev_r    <= cfg_wdata[0];
        CFG_REGION_FIRST:  region_first_r <= cfg_wdata[REGION_W-1:0];
        CFG_REGION_LAST:   region_last_r  <= cfg_wdata[REGION_W-1:0];
        default: ;
      endcase
    end
  end

  // precompute strand base: start, or source length minus start
  always_ff @(posedge clk) begin
    ref_base_r   <= ref_rev_r ? (POS_W'(ref_len_r) - POS_W'(ref_start_r))
                              : POS_W'(ref_start_r);
    other_base_r <= other_rev_r ? (POS_W'(other_len_r) - POS_W'(other_start_r))
                                : POS_W'(other_start_r);
  end

  assign out_load = !out_valid_r || out_ready;
  assign seg_load = !seg_valid_r || out_load;
  assign in_ready = !in_valid_r || seg_load;
  assign step     = in_valid_r && seg_load;

  agrs_tracker #(
    .COLUMN_BITS (COLUMN_BITS)
  ) u_tracker (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .ref_char     (ref_char_r),
    .other_char   (other_char_r),
    .block_begin  (begin_r),
    .region_first (region_first_r),
    .region_last  (region_last_r),
    .emit         (emit),
    .seg_len      (trk_len),
    .ref_local    (trk_ref),
    .other_local  (trk_other)
  );

  always_comb begin
    ref_c         = POS_W'($signed(seg_ref_r));
    other_c       = POS_W'($signed(seg_other_r));
    len_ext       = POS_W'(seg_len_r);
    ref_pos_nxt   = ref_rev_r ? (ref_base_r - len_ext - ref_c) : (ref_base_r + ref_c);
    other_pos_nxt = other_rev_r ? (other_base_r - len_ext - other_c)
                                : (other_base_r + other_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      seg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (seg_load) begin
        seg_valid_r <= step && emit;
      end
      if (out_load) begin
        out_valid_r <= seg_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ref_char_r   <= in_ref_char;
      other_char_r <= in_other_char;
      begin_r      <= in_block_begin;
    end
    if (step && emit) begin
      seg_len_r   <= trk_len;
      seg_ref_r   <= trk_ref;
      seg_other_r <= trk_other;
    end
    if (out_load && seg_valid_r) begin
      out_ref_pos_r   <= ref_pos_nxt;
      out_other_pos_r <= other_pos_nxt;
      out_len_r       <= seg_len_r;
      out_same_r      <= (ref_rev_r == other_rev_r);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_ref_position     = $signed(out_ref_pos_r);
  assign out_other_position   = $signed(out_other_pos_r);
  assign out_run_length       = out_len_r;
  assign out_same_orientation = out_same_r;

endmodule

// ----- hw/rtl/agrs_checker.sv -----
// ----------------------------------------------------------------------------
// agrs_checker
// Port-level checks of the segmenter, bound to the top level.
// ----------------------------------------------------------------------------
module agrs_checker #(
  parameter int unsigned COLUMN_BITS = agrs_pkg::DEFAULT_COLUMN_BITS
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [agrs_pkg::POS_W-1:0] out_ref_position,
  input logic signed [agrs_pkg::POS_W-1:0] out_other_position,
  input logic [COLUMN_BITS:0]              out_run_length,
  input logic                              out_same_orientation
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ref_position) &&
      $stable(out_other_position) && $stable(out_run_length) &&
      $stable(out_same_orientation))
    else $error("result beat changed while stalled");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_run_length != '0)
    else $error("empty segment emitted");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with free output");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind alignment_gap_run_segmenter agrs_checker #(
  .COLUMN_BITS (COLUMN_BITS)
) u_agrs_checker (.*);

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams alignment columns through the gap-run segmenter under random
// stalls on both channels and across several register settings. A local
// tracker of the gap counters and the open run predicts each segment, and
// every beat on the result channel is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
  import agrs_pkg::*;

  localparam int unsigned COL_W       = DEFAULT_COLUMN_BITS;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned PHASES      = 10;

  typedef struct {
    logic [CHAR_W-1:0] ref_char;
    logic [CHAR_W-1:0] other_char;
    logic              block_begin;
  } column_t;

  typedef struct {
    logic signed [POS_W-1:0] ref_pos;
    logic signed [POS_W-1:0] other_pos;
    logic [COL_W:0]          run_len;
    logic                    same;
  } segment_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
  logic [CFG_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [CHAR_W-1:0]       in_ref_char = '0;
  logic [CHAR_W-1:0]       in_other_char = '0;
  logic                    in_block_begin = 1'b0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [POS_W-1:0] out_ref_position;
  logic signed [POS_W-1:0] out_other_position;
  logic [COL_W:0]          out_run_length;
  logic                    out_same_orientation;

  // register shadow
  logic [COORD_W-1:0]  ref_start_r = '0;
  logic [COORD_W-1:0]  ref_len_r = '0;
  logic                ref_rev_r = 1'b0;
  logic [COORD_W-1:0]  other_start_r = '0;
  logic [COORD_W-1:0]  other_len_r = '0;
  logic                other_rev_r = 1'b0;
  logic [REGION_W-1:0] first_r = '0;
  logic [REGION_W-1:0] last_r = '0;

  // tracker state
  logic [COL_W-1:0] col_idx = '0;
  logic [COL_W:0]   ref_gaps = '0;
  logic [COL_W:0]   other_gaps = '0;
  logic             in_run = 1'b0;
  logic [COL_W:0]   run_cnt = '0;
  logic [COL_W:0]   ref_loc = '0;
  logic [COL_W:0]   other_loc = '0;

  column_t  column_q[$];
  segment_t segment_q[$];
  column_t  sent;
  int       errors = 0;
  int       idle_pct = 0;
  int       hold_requests = 0;
  int       holds_done = 0;
  int       send_gap = 0;
  int       recv_gap = 0;
  int       quiet = 0;

  alignment_gap_run_segmenter #(.COLUMN_BITS(COL_W)) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_ref_char          (in_ref_char),
    .in_other_char        (in_other_char),
    .in_block_begin       (in_block_begin),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_ref_position     (out_ref_position),
    .out_other_position   (out_other_position),
    .out_run_length       (out_run_length),
    .out_same_orientation (out_same_orientation)
  );

  always #6 clk = ~clk;

  function automatic logic [POS_W-1:0] plus_strand_start(
    input logic [COL_W:0] loc, input logic [COORD_W-1:0] start,
    input logic [COORD_W-1:0] src_len, input logic rev, input logic [COL_W:0] len);
    longint c;
    longint g;
    c = loc[COL_W] ? longint'(loc) - (longint'(1) << (COL_W + 1)) : longint'(loc);
    if (rev) g = longint'(src_len) - longint'(start) - longint'(len) - c;
    else g = longint'(start) + c;
    return g[POS_W-1:0];
  endfunction

  function automatic void close_run();
    segment_t s;
    s.ref_pos   = plus_strand_start(ref_loc, ref_start_r, ref_len_r, ref_rev_r, run_cnt);
    s.other_pos = plus_strand_start(other_loc, other_start_r, other_len_r, other_rev_r,
                                    run_cnt);
    s.run_len   = run_cnt;
    s.same      = (ref_rev_r == other_rev_r);
    segment_q.push_back(s);
    in_run  = 1'b0;
    run_cnt = '0;
  endfunction

  function automatic void advance_tracker(input column_t c);
    logic [COL_W-1:0] col;
    logic             other_gap;
    other_gap = (c.other_char == GAP_CHAR);
    if (c.block_begin) begin
      col        = '0;
      ref_gaps   = '0;
      other_gaps = '0;
      in_run     = 1'b0;
      run_cnt    = '0;
    end else begin
      col = col_idx;
    end
    if (c.ref_char == GAP_CHAR) ref_gaps = ref_gaps + 1'b1;
    if (other_gap) other_gaps = other_gaps + 1'b1;
    if (col >= first_r && col <= last_r) begin
      if (other_gap) begin
        if (in_run) close_run();
      end else begin
        if (!in_run) begin
          in_run    = 1'b1;
          run_cnt   = '0;
          ref_loc   = {1'b0, col} - ref_gaps;
          other_loc = {1'b0, col} - other_gaps;
        end
        run_cnt = run_cnt + 1'b1;
        if (col == last_r) close_run();
      end
    end
    col_idx = col + 1'b1;
  endfunction

  function automatic void check_segment();
    segment_t e;
    if (segment_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected segment ref %0d other %0d len %0d same %0b", $time,
               out_ref_position, out_other_position, out_run_length, out_same_orientation);
      return;
    end
    e = segment_q.pop_front();
    if (out_ref_position !== e.ref_pos) begin
      errors++;
      $display("%0t: ref_position expected %0d actual %0d", $time, e.ref_pos,
               out_ref_position);
    end
    if (out_other_position !== e.other_pos) begin
      errors++;
      $display("%0t: other_position expected %0d actual %0d", $time, e.other_pos,
               out_other_position);
    end
    if (out_run_length !== e.run_len) begin
      errors++;
      $display("%0t: run_length expected %0d actual %0d", $time, e.run_len, out_run_length);
    end
    if (out_same_orientation !== e.same) begin
      errors++;
      $display("%0t: same_orientation expected %0b actual %0b", $time, e.same,
               out_same_orientation);
    end
  endfunction

  // column driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) advance_tracker(sent);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (column_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
          send_gap = $urandom_range(13);
          in_valid <= 1'b0;
        end else begin
          sent = column_q.pop_front();
          in_valid       <= 1'b1;
          in_ref_char    <= sent.ref_char;
          in_other_char  <= sent.other_char;
          in_block_begin <= sent.block_begin;
        end
      end
    end
  end

  // segment monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && out_ready) check_segment();
      if (holds_done < hold_requests) begin
        holds_done++;
        recv_gap = LONG_HOLD;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
        recv_gap = $urandom_range(13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic drain();
    do @(posedge clk); while (column_q.size() != 0 || in_valid || segment_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_REF_START:     ref_start_r = val;
      CFG_REF_SRC_LEN:   ref_len_r = val;
      CFG_REF_REVERSE:   ref_rev_r = val[0];
      CFG_OTHER_START:   other_start_r = val;
      CFG_OTHER_SRC_LEN: other_len_r = val;
      CFG_OTHER_REVERSE: other_rev_r = val[0];
      CFG_REGION_FIRST:  first_r = val[REGION_W-1:0];
      CFG_REGION_LAST:   last_r = val[REGION_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [CFG_W-1:0] rs, input logic [CFG_W-1:0] rl,
    input logic [CFG_W-1:0] rr, input logic [CFG_W-1:0] os, input logic [CFG_W-1:0] ol,
    input logic [CFG_W-1:0] orv, input logic [CFG_W-1:0] rf, input logic [CFG_W-1:0] rlast);
    cfg_write(CFG_REF_START, rs);
    cfg_write(CFG_REF_SRC_LEN, rl);
    cfg_write(CFG_REF_REVERSE, rr);
    cfg_write(CFG_OTHER_START, os);
    cfg_write(CFG_OTHER_SRC_LEN, ol);
    cfg_write(CFG_OTHER_REVERSE, orv);
    cfg_write(CFG_REGION_FIRST, rf);
    cfg_write(CFG_REGION_LAST, rlast);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void push_column(input logic [CHAR_W-1:0] r, input logic [CHAR_W-1:0] o,
                                      input logic b);
    column_t c;
    c.ref_char    = r;
    c.other_char  = o;
    c.block_begin = b;
    column_q.push_back(c);
  endfunction

  function automatic logic [CHAR_W-1:0] rand_char(input int gap_pct);
    if ($urandom_range(99) < gap_pct) return GAP_CHAR;
    return CHAR_W'($urandom_range(255));
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2, 3: return COORD_W'($urandom_range(5000));
      default: return $urandom;
    endcase
  endfunction

  task automatic random_config(input int p);
    logic [REGION_W-1:0] f;
    logic [REGION_W-1:0] l;
    logic [CFG_W-1:0]    junk;
    junk = $urandom;
    f = REGION_W'($urandom_range(6));
    case ($urandom_range(5))
      0: begin
        f = REGION_W'($urandom_range(2, 6));
        l = f - REGION_W'($urandom_range(1, 2));
      end
      1: l = '1;
      default: l = f + REGION_W'($urandom_range(40));
    endcase
    if (p == 0) load_config('1, '1, 1, '1, '1, 1, 0, {12'h0, 20'hFFFFF});
    else if (p == 1) load_config('0, '0, 0, '0, '0, 0, 0, 3);
    else load_config(rand_coord(), rand_coord(), {junk[31:1], 1'($urandom_range(1))},
                     rand_coord(), rand_coord(), {junk[31:1], 1'($urandom_range(1))},
                     {junk[31:20], f}, {junk[31:20], l});
  endtask

  // blocks of random content; a few carry heavy gap noise or a stray block start
  function automatic void fill_phase();
    int n;
    int len;
    int gap_pct;
    n = 0;
    while (n < PHASE_ITEMS) begin
      len     = ($urandom_range(9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
      gap_pct = ($urandom_range(7) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 35);
      for (int i = 0; i < len; i++)
        push_column(rand_char(gap_pct), rand_char(gap_pct),
                    (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(99) < 2));
      n += len;
    end
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // first columns after reset without a block start
    push_column("A", "C", 1'b0);
    push_column(GAP_CHAR, "G", 1'b0);
    drain();

    load_config(1000, 5000, 0, 200, 900, 1, 0, 6);
    // reference gap at run start, other gap closing, gap at last column
    push_column(GAP_CHAR, "A", 1'b1);
    push_column(8'h00, 8'hFF, 1'b0);
    push_column("C", GAP_CHAR, 1'b0);
    push_column(GAP_CHAR, GAP_CHAR, 1'b0);
    push_column(8'hFF, 8'h00, 1'b0);
    push_column("T", "G", 1'b0);
    push_column("A", GAP_CHAR, 1'b0);
    // drop an open run on a new block, then run to the region end
    push_column("A", "C", 1'b1);
    push_column("A", "C", 1'b0);
    push_column("G", "G", 1'b1);
    for (int i = 0; i < 6; i++) push_column("A", "A", 1'b0);
    drain();

    // empty region
    load_config('1, '0, 1, '0, '1, 1, {12'h0, 20'hFFFFF}, 3);
    push_column("A", "A", 1'b1);
    for (int i = 0; i < 4; i++) push_column("C", "T", 1'b0);
    drain();

    load_config('1, '0, 1, '0, '1, 0, 1, {12'h0, 20'hFFFFF});
    push_column("A", "A", 1'b1);
    push_column("A", "A", 1'b0);
    push_column(GAP_CHAR, "A", 1'b0);
    push_column("A", GAP_CHAR, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      random_config(p);
      idle_pct = (p % 3 == 1 || p == PHASES - 1) ? 0 : 12;
      if (p == 0) hold_requests++;
      fill_phase();
    end

    drain();
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
